FILE: sv/bipolar_threshold_hit_finder_unit_assert.svh
// Assertion macros shared by the hit finder modules.
// Each expects clk_i and rst_ni in the enclosing module.
`ifndef BIPOLAR_THRESHOLD_HIT_FINDER_UNIT_ASSERT_SVH
`define BIPOLAR_THRESHOLD_HIT_FINDER_UNIT_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define BTHF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hit finder assertion failed");

// When ante holds, cons must hold in the next cycle.
`define BTHF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hit finder assertion failed");

`endif

FILE: sv/bthf_pkg.sv
`timescale 1ns / 1ps

package bthf_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int CHAN_W           = 16;
  localparam int THR_W            = 15;
  localparam int DS_W             = 7;
  localparam int DIV_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int OUT_TIME_W       = 24;
  localparam int OUT_POS_CHARGE_W = 32;
  localparam int OUT_NEG_CHARGE_W = 31;

  localparam int TIME_BITS_DEF    = 24;
  localparam int CHARGE_BITS_DEF  = 32;

  localparam int QUEUE_DEPTH      = 2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd20;
  localparam logic [DS_W-1:0]  DS_RST        = 7'd1;
  localparam logic [DIV_W-1:0] DIVISOR_RST   = 16'd99;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_DS_FACTOR = 2'd1,
    CFG_DIVISOR   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [DS_W-1:0]  ds;
    logic [DIV_W-1:0] divisor;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_NEG,
    ST_PREP_POS,
    ST_DIV_POS,
    ST_SEND
  } back_state_e;

endpackage

FILE: sv/bthf_front.sv
`timescale 1ns / 1ps

module bthf_front #(
  parameter int TIME_BITS   = bthf_pkg::TIME_BITS_DEF,
  parameter int CHARGE_BITS = bthf_pkg::CHARGE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bthf_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [bthf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [bthf_pkg::CHAN_W-1:0]          channel_id_i,
  input  logic                                 first_sample_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output logic [bthf_pkg::CHAN_W-1:0]          job_chan_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]      job_pos_start_o,
  output logic [CHARGE_BITS-2:0]               job_pos_sum_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]      job_pos_ticks_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]      job_neg_start_o,
  output logic [CHARGE_BITS-2:0]               job_neg_sum_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]      job_neg_ticks_o,
  output logic                                 job_pos_div_o,
  output logic [bthf_pkg::DIV_W-1:0]           job_pos_dvsr_o
);

  localparam int CW = CHARGE_BITS - 1;
  localparam int PW = bthf_pkg::SAMPLE_W + bthf_pkg::DS_W;
  localparam int EW = ((CW > PW) ? CW : PW) + 1;
  localparam int TW = TIME_BITS;

  logic                          in_pos_q, in_pos_d, in_neg_q, in_neg_d;
  logic [TW-1:0]                 tick_q, tick_d;
  logic [bthf_pkg::CHAN_W-1:0]   chan_q, chan_d;
  logic [TW-1:0]                 pos_start_q, pos_start_d, pos_ticks_q, pos_ticks_d;
  logic [CW-1:0]                 pos_sum_q, pos_sum_d;
  logic                          pos_div_q, pos_div_d;
  logic [bthf_pkg::DIV_W-1:0]    pos_dvsr_q, pos_dvsr_d;
  logic [TW-1:0]                 neg_start_q, neg_start_d, neg_ticks_q, neg_ticks_d;
  logic [CW-1:0]                 neg_sum_q, neg_sum_d;

  logic                          first;
  logic                          in_pos_eff, in_neg_eff, pos_div_eff;
  logic [TW-1:0]                 tick_eff, pos_start_eff, pos_ticks_eff;
  logic [TW-1:0]                 neg_start_eff, neg_ticks_eff;
  logic [CW-1:0]                 pos_sum_eff, neg_sum_eff;

  logic                          is_pos, is_neg, cont, neg_end, accept;
  logic signed [bthf_pkg::SAMPLE_W:0] neg_thr;
  logic [bthf_pkg::SAMPLE_W-1:0] mag;
  logic [PW-1:0]                 prod;
  logic [CW-1:0]                 acc_in, acc_sat;
  logic [EW-1:0]                 acc_sum;
  logic [TW-1:0]                 ticks_in, ticks_sat, tick_sat;
  logic [TW:0]                   ticks_sum, tick_sum;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !q_full_i;

  // a first sample clears the record before this sample is looked at
  assign first         = first_sample_i;
  assign in_pos_eff    = first ? 1'b0 : in_pos_q;
  assign in_neg_eff    = first ? 1'b0 : in_neg_q;
  assign pos_div_eff   = first ? 1'b0 : pos_div_q;
  assign tick_eff      = first ? '0 : tick_q;
  assign pos_start_eff = first ? '0 : pos_start_q;
  assign pos_ticks_eff = first ? '0 : pos_ticks_q;
  assign pos_sum_eff   = first ? '0 : pos_sum_q;
  assign neg_start_eff = first ? '0 : neg_start_q;
  assign neg_ticks_eff = first ? '0 : neg_ticks_q;
  assign neg_sum_eff   = first ? '0 : neg_sum_q;

  assign neg_thr = -$signed({2'b00, cfg_i.threshold});
  assign is_pos  = sample_i > $signed({1'b0, cfg_i.threshold});
  assign is_neg  = $signed({sample_i[bthf_pkg::SAMPLE_W-1], sample_i}) < neg_thr;

  // a sample is in at most one lobe, so one accumulator serves both
  assign mag      = is_neg ? (~sample_i + 16'd1) : sample_i;
  assign prod     = PW'(mag) * PW'(cfg_i.ds);
  assign cont     = is_pos ? in_pos_eff : in_neg_eff;
  assign acc_in   = is_pos ? pos_sum_eff : neg_sum_eff;
  assign acc_sum  = cont ? (EW'(acc_in) + EW'(prod)) : EW'(mag);
  assign acc_sat  = (|acc_sum[EW-1:CW]) ? {CW{1'b1}} : acc_sum[CW-1:0];

  assign ticks_in  = cont ? (is_pos ? pos_ticks_eff : neg_ticks_eff) : '0;
  assign ticks_sum = (TW+1)'(ticks_in) + (TW+1)'(cfg_i.ds);
  assign ticks_sat = ticks_sum[TW] ? {TW{1'b1}} : ticks_sum[TW-1:0];
  assign tick_sum  = (TW+1)'(tick_eff) + (TW+1)'(cfg_i.ds);
  assign tick_sat  = tick_sum[TW] ? {TW{1'b1}} : tick_sum[TW-1:0];

  always_comb begin
    in_pos_d    = is_pos;
    in_neg_d    = is_neg;
    tick_d      = tick_sat;
    chan_d      = first ? channel_id_i : chan_q;
    pos_start_d = pos_start_eff;
    pos_sum_d   = pos_sum_eff;
    pos_ticks_d = pos_ticks_eff;
    pos_div_d   = pos_div_eff;
    pos_dvsr_d  = pos_dvsr_q;
    neg_start_d = neg_start_eff;
    neg_sum_d   = neg_sum_eff;
    neg_ticks_d = neg_ticks_eff;
    neg_end     = !is_neg && in_neg_eff;

    if (is_pos) begin
      pos_sum_d   = acc_sat;
      pos_ticks_d = ticks_sat;
      if (!in_pos_eff) begin
        pos_start_d = tick_eff;
        pos_div_d   = 1'b0;
      end
    end else if (in_pos_eff) begin
      // lobe closed: division is deferred, remember the gain in force now
      pos_div_d  = 1'b1;
      pos_dvsr_d = cfg_i.divisor;
    end

    if (is_neg) begin
      neg_sum_d   = acc_sat;
      neg_ticks_d = ticks_sat;
      if (!in_neg_eff) begin
        neg_start_d = tick_eff;
      end
    end
  end

  assign push_o          = accept && neg_end;
  assign job_chan_o      = chan_d;
  assign job_pos_start_o = bthf_pkg::OUT_TIME_W'(pos_start_d);
  assign job_pos_sum_o   = pos_sum_d;
  assign job_pos_ticks_o = bthf_pkg::OUT_TIME_W'(pos_ticks_d);
  assign job_neg_start_o = bthf_pkg::OUT_TIME_W'(neg_start_d);
  assign job_neg_sum_o   = neg_sum_d;
  assign job_neg_ticks_o = bthf_pkg::OUT_TIME_W'(neg_ticks_d);
  assign job_pos_div_o   = pos_div_d;
  assign job_pos_dvsr_o  = pos_dvsr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q    <= 1'b0;
      in_neg_q    <= 1'b0;
      tick_q      <= '0;
      chan_q      <= '0;
      pos_start_q <= '0;
      pos_sum_q   <= '0;
      pos_ticks_q <= '0;
      pos_div_q   <= 1'b0;
      pos_dvsr_q  <= '0;
      neg_start_q <= '0;
      neg_sum_q   <= '0;
      neg_ticks_q <= '0;
    end else if (accept) begin
      in_pos_q    <= in_pos_d;
      in_neg_q    <= in_neg_d;
      tick_q      <= tick_d;
      chan_q      <= chan_d;
      pos_start_q <= pos_start_d;
      pos_sum_q   <= pos_sum_d;
      pos_ticks_q <= pos_ticks_d;
      pos_div_q   <= pos_div_d;
      pos_dvsr_q  <= pos_dvsr_d;
      neg_start_q <= neg_start_d;
      neg_sum_q   <= neg_sum_d;
      neg_ticks_q <= neg_ticks_d;
    end
  end

endmodule

FILE: sv/bthf_fifo.sv
`timescale 1ns / 1ps

module bthf_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  `include "bipolar_threshold_hit_finder_unit_assert.svh"

  localparam int DEPTH = bthf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // a push into a full queue would drop a hit
  `BTHF_ASSERT(a_no_push_full, !(push_i && full_o))
  `BTHF_ASSERT_NEXT(a_drain_empty, pop_i && !push_i && (count_q == CNT_W'(1)), empty_o)

endmodule

FILE: sv/bthf_back.sv
`timescale 1ns / 1ps

module bthf_back #(
  parameter int CHARGE_BITS = bthf_pkg::CHARGE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  bthf_pkg::cfg_t                               cfg_i,
  input  logic                                         q_empty_i,
  output logic                                         pop_o,
  input  logic [bthf_pkg::CHAN_W-1:0]                  job_chan_i,
  input  logic [bthf_pkg::OUT_TIME_W-1:0]              job_pos_start_i,
  input  logic [CHARGE_BITS-2:0]                       job_pos_sum_i,
  input  logic [bthf_pkg::OUT_TIME_W-1:0]              job_pos_ticks_i,
  input  logic [bthf_pkg::OUT_TIME_W-1:0]              job_neg_start_i,
  input  logic [CHARGE_BITS-2:0]                       job_neg_sum_i,
  input  logic [bthf_pkg::OUT_TIME_W-1:0]              job_neg_ticks_i,
  input  logic                                         job_pos_div_i,
  input  logic [bthf_pkg::DIV_W-1:0]                   job_pos_dvsr_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [bthf_pkg::CHAN_W-1:0]                  hit_channel_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              pos_start_time_o,
  output logic signed [bthf_pkg::OUT_POS_CHARGE_W-1:0] pos_charge_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              pos_time_over_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              neg_start_time_o,
  output logic [bthf_pkg::OUT_NEG_CHARGE_W-1:0]        neg_charge_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              neg_time_over_o
);

  `include "bipolar_threshold_hit_finder_unit_assert.svh"

  localparam int DW    = CHARGE_BITS - 1;
  localparam int CNT_W = $clog2(DW);
  localparam int VW    = bthf_pkg::DIV_W;

  bthf_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [bthf_pkg::CHAN_W-1:0]     chan_q;
  logic [bthf_pkg::OUT_TIME_W-1:0] pos_start_q, pos_ticks_q, neg_start_q, neg_ticks_q;
  logic [DW-1:0]                   pos_sum_q, neg_sum_q, pos_res_q, neg_res_q, quo_q;
  logic                            pdiv_q;
  logic [VW-1:0]                   pdvsr_q, dvsr_q, rem_q;

  logic          div_step, div_last;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW-1:0] rem_next;
  logic [DW-1:0] quo_next;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem_q, quo_q[DW-1]};
  assign ge       = trial >= {1'b0, dvsr_q};
  assign rem_next = ge ? VW'(trial - {1'b0, dvsr_q}) : trial[VW-1:0];
  assign quo_next = {quo_q[DW-2:0], ge};
  assign div_last = (cnt_q == CNT_W'(DW - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bthf_pkg::ST_IDLE:     if (!q_empty_i) state_d = bthf_pkg::ST_DIV_NEG;
      bthf_pkg::ST_DIV_NEG:  if (div_last) state_d = bthf_pkg::ST_PREP_POS;
      bthf_pkg::ST_PREP_POS: state_d = pdiv_q ? bthf_pkg::ST_DIV_POS : bthf_pkg::ST_SEND;
      bthf_pkg::ST_DIV_POS:  if (div_last) state_d = bthf_pkg::ST_SEND;
      bthf_pkg::ST_SEND:     if (out_ready_i) state_d = bthf_pkg::ST_IDLE;
      default:               state_d = bthf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == bthf_pkg::ST_IDLE) && !q_empty_i;
    div_step    = (state_q == bthf_pkg::ST_DIV_NEG) || (state_q == bthf_pkg::ST_DIV_POS);
    out_valid_o = (state_q == bthf_pkg::ST_SEND);
    cnt_d       = div_step ? cnt_q + CNT_W'(1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bthf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      chan_q      <= job_chan_i;
      pos_start_q <= job_pos_start_i;
      pos_sum_q   <= job_pos_sum_i;
      pos_ticks_q <= job_pos_ticks_i;
      neg_start_q <= job_neg_start_i;
      neg_sum_q   <= job_neg_sum_i;
      neg_ticks_q <= job_neg_ticks_i;
      pdiv_q      <= job_pos_div_i;
      pdvsr_q     <= job_pos_dvsr_i;
      dvsr_q      <= cfg_i.divisor;
      quo_q       <= job_neg_sum_i;
      rem_q       <= '0;
    end
    if (state_q == bthf_pkg::ST_PREP_POS) begin
      dvsr_q    <= pdvsr_q;
      quo_q     <= pos_sum_q;
      rem_q     <= '0;
      pos_res_q <= pos_sum_q;
    end
    if (div_step) begin
      quo_q <= quo_next;
      rem_q <= rem_next;
    end
    // a zero gain leaves the charge as it is
    if ((state_q == bthf_pkg::ST_DIV_NEG) && div_last) begin
      neg_res_q <= (dvsr_q == '0) ? neg_sum_q : quo_next;
    end
    if ((state_q == bthf_pkg::ST_DIV_POS) && div_last) begin
      pos_res_q <= (dvsr_q == '0) ? pos_sum_q : quo_next;
    end
  end

  assign hit_channel_o    = chan_q;
  assign pos_start_time_o = pos_start_q;
  assign pos_charge_o     = $signed(bthf_pkg::OUT_POS_CHARGE_W'(pos_res_q));
  assign pos_time_over_o  = pos_ticks_q;
  assign neg_start_time_o = neg_start_q;
  assign neg_charge_o     = bthf_pkg::OUT_NEG_CHARGE_W'(neg_res_q);
  assign neg_time_over_o  = neg_ticks_q;

  `BTHF_ASSERT(a_cnt_bound, !div_step || (cnt_q <= CNT_W'(DW - 1)))
  `BTHF_ASSERT_NEXT(a_pop_starts_div, pop_o, state_q == bthf_pkg::ST_DIV_NEG)

endmodule

FILE: sv/bipolar_threshold_hit_finder_unit.sv
`timescale 1ns / 1ps

// Bipolar threshold hit finder.
// Input channel (in_valid_i/in_ready_o): one filtered sample word per
// transfer; first_sample_i starts a new waveform and latches channel_id_i.
// Output channel (out_valid_o/out_ready_i): one hit word each time a negative
// lobe ends, carrying both lobes' start time, charge and time over threshold.
// Config: cfg_we_i writes cfg_data_i to register cfg_index_i (0 threshold,
// 1 downsample factor, 2 charge divisor) in the same cycle; write only idle.
// Throughput: the front takes one sample per cycle while the two-entry hit
// queue has room. The back divides charges bit-serially: the negative charge
// always, the positive charge too when the job's division flag is set. It
// pops the next hit only after the current hit word has been taken.
// A stalled receiver holds the hit word; the queue absorbs two more hits,
// then in_ready_o drops until the back frees an entry.
// Reset clears lobe state, time counter, channel and queue and loads the
// registers with threshold 20, factor 1, divisor 99.

module bipolar_threshold_hit_finder_unit #(
  parameter int TIME_BITS   = bthf_pkg::TIME_BITS_DEF,
  parameter int CHARGE_BITS = bthf_pkg::CHARGE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [bthf_pkg::CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [bthf_pkg::CFG_DATA_W-1:0]              cfg_data_i,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic signed [bthf_pkg::SAMPLE_W-1:0]         sample_i,
  input  logic [bthf_pkg::CHAN_W-1:0]                  channel_id_i,
  input  logic                                         first_sample_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [bthf_pkg::CHAN_W-1:0]                  hit_channel_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              pos_start_time_o,
  output logic signed [bthf_pkg::OUT_POS_CHARGE_W-1:0] pos_charge_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              pos_time_over_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              neg_start_time_o,
  output logic [bthf_pkg::OUT_NEG_CHARGE_W-1:0]        neg_charge_o,
  output logic [bthf_pkg::OUT_TIME_W-1:0]              neg_time_over_o
);

  localparam int CW     = CHARGE_BITS - 1;
  localparam int TO     = bthf_pkg::OUT_TIME_W;
  localparam int JOB_W  = bthf_pkg::CHAN_W + 4 * TO + 2 * CW + 1 + bthf_pkg::DIV_W;

  bthf_pkg::cfg_t cfg_q;

  logic                        q_full, q_empty, push, pop;
  logic [JOB_W-1:0]            q_wdata, q_rdata;

  logic [bthf_pkg::CHAN_W-1:0] f_chan, b_chan;
  logic [TO-1:0]               f_pos_start, f_pos_ticks, f_neg_start, f_neg_ticks;
  logic [TO-1:0]               b_pos_start, b_pos_ticks, b_neg_start, b_neg_ticks;
  logic [CW-1:0]               f_pos_sum, f_neg_sum, b_pos_sum, b_neg_sum;
  logic                        f_pos_div, b_pos_div;
  logic [bthf_pkg::DIV_W-1:0]  f_pos_dvsr, b_pos_dvsr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= bthf_pkg::THRESHOLD_RST;
      cfg_q.ds        <= bthf_pkg::DS_RST;
      cfg_q.divisor   <= bthf_pkg::DIVISOR_RST;
    end else if (cfg_we_i) begin
      unique case (bthf_pkg::cfg_idx_e'(cfg_index_i))
        bthf_pkg::CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[bthf_pkg::THR_W-1:0];
        bthf_pkg::CFG_DS_FACTOR: cfg_q.ds        <= cfg_data_i[bthf_pkg::DS_W-1:0];
        bthf_pkg::CFG_DIVISOR:   cfg_q.divisor   <= cfg_data_i[bthf_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  bthf_front #(
    .TIME_BITS   (TIME_BITS),
    .CHARGE_BITS (CHARGE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .channel_id_i    (channel_id_i),
    .first_sample_i  (first_sample_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_chan_o      (f_chan),
    .job_pos_start_o (f_pos_start),
    .job_pos_sum_o   (f_pos_sum),
    .job_pos_ticks_o (f_pos_ticks),
    .job_neg_start_o (f_neg_start),
    .job_neg_sum_o   (f_neg_sum),
    .job_neg_ticks_o (f_neg_ticks),
    .job_pos_div_o   (f_pos_div),
    .job_pos_dvsr_o  (f_pos_dvsr)
  );

  assign q_wdata = {f_chan, f_pos_start, f_pos_sum, f_pos_ticks, f_neg_start,
                    f_neg_sum, f_neg_ticks, f_pos_div, f_pos_dvsr};

  bthf_fifo #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_chan, b_pos_start, b_pos_sum, b_pos_ticks, b_neg_start,
          b_neg_sum, b_neg_ticks, b_pos_div, b_pos_dvsr} = q_rdata;

  bthf_back #(
    .CHARGE_BITS (CHARGE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_empty_i        (q_empty),
    .pop_o            (pop),
    .job_chan_i       (b_chan),
    .job_pos_start_i  (b_pos_start),
    .job_pos_sum_i    (b_pos_sum),
    .job_pos_ticks_i  (b_pos_ticks),
    .job_neg_start_i  (b_neg_start),
    .job_neg_sum_i    (b_neg_sum),
    .job_neg_ticks_i  (b_neg_ticks),
    .job_pos_div_i    (b_pos_div),
    .job_pos_dvsr_i   (b_pos_dvsr),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_channel_o    (hit_channel_o),
    .pos_start_time_o (pos_start_time_o),
    .pos_charge_o     (pos_charge_o),
    .pos_time_over_o  (pos_time_over_o),
    .neg_start_time_o (neg_start_time_o),
    .neg_charge_o     (neg_charge_o),
    .neg_time_over_o  (neg_time_over_o)
  );

endmodule
